// File: rtl/stt_pkg.sv
package stt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = 7;
  localparam int CMP_W       = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_KNOWN    = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_READ_OK  = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  typedef struct packed {
    logic signed [31:0] stream_id;
    logic [31:0]        frame_type;
    logic [63:0]        start_time;
    logic [63:0]        end_time;
    logic [31:0]        frame_count;
  } entry_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [IDX_W-1:0]   slot;
    logic signed [31:0] entry_stream_id;
    logic [31:0]        entry_frame_type;
    logic [63:0]        start_time;
    logic [63:0]        end_time;
    logic [31:0]        frame_count;
    logic [7:0]         streams_seen;
  } result_t;

  function automatic result_t blank_result(logic [2:0] status, logic [IDX_W-1:0] slot,
                                           logic [7:0] seen);
    result_t r;
    r = '0;
    r.status       = status;
    r.slot         = slot;
    r.streams_seen = seen;
    return r;
  endfunction

  function automatic result_t entry_result(logic [2:0] status, logic [IDX_W-1:0] slot,
                                           entry_t e, logic [7:0] seen);
    result_t r;
    r.status           = status;
    r.slot             = slot;
    r.entry_stream_id  = e.stream_id;
    r.entry_frame_type = e.frame_type;
    r.start_time       = e.start_time;
    r.end_time         = e.end_time;
    r.frame_count      = e.frame_count;
    r.streams_seen     = seen;
    return r;
  endfunction

endpackage

// File: rtl/stt_ifs.sv
interface stt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] stream_id;
  logic [31:0]        frame_type;
  logic [63:0]        time_tag;
  logic [6:0]         entry_index;

  modport source(output valid, operation, stream_id, frame_type, time_tag, entry_index,
                 input ready);
  modport sink(input valid, operation, stream_id, frame_type, time_tag, entry_index,
               output ready);
endinterface

interface stt_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [6:0]         slot;
  logic signed [31:0] entry_stream_id;
  logic [31:0]        entry_frame_type;
  logic [63:0]        start_time;
  logic [63:0]        end_time;
  logic [31:0]        frame_count;
  logic [7:0]         streams_seen;

  modport source(output valid, status, slot, entry_stream_id, entry_frame_type, start_time,
                 end_time, frame_count, streams_seen, input ready);
  modport sink(input valid, status, slot, entry_stream_id, entry_frame_type, start_time,
               end_time, frame_count, streams_seen, output ready);
endinterface

// File: rtl/stream_statistics_table.sv
// Channel  Dir  Transfer carries
// -------  ---  ------------------------------------------------------------
// req      in   operation, stream_id, frame_type, time_tag, entry_index
// rsp      out  status, slot, entry fields, frame_count, streams_seen
//
// A record searches the valid entries in slot order and stops at the first hit: the
// search reads the entry memory one entry per cycle and compares each entry in the cycle after.
// A read in range goes through the entry memory; clear, empty reads and ignored records do not.
// Reset is synchronous and empties the table; entry contents are never erased.
// A finished result waits in the output register while the next request is taken.
module stream_statistics_table (
  input  logic clk,
  input  logic rst,
  stt_in_if.sink    req,
  stt_out_if.source rsp
);

  localparam int ADDR_W  = stt_pkg::ADDR_W;
  localparam int COUNT_W = stt_pkg::COUNT_W;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_READ, S_EMIT} state_t;

  state_t               state;
  logic [COUNT_W-1:0]   valid_entries;
  logic [COUNT_W-1:0]   scan;
  logic                 stopped;
  logic                 rdv;
  logic [ADDR_W-1:0]    rd_slot;
  logic signed [31:0]   op_id;
  logic [31:0]          op_type;
  logic [63:0]          op_tag;
  stt_pkg::result_t     res;
  stt_pkg::result_t     out_reg;
  logic                 out_valid;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ADDR_W-1:0]    ram_raddr;
  stt_pkg::entry_t      ram_wdata;
  stt_pkg::entry_t      ram_q;

  logic issue, hit, miss, full, idx_in_range;

  assign issue = scan < valid_entries;
  assign hit   = (state == S_SEARCH) && rdv && (ram_q.stream_id == op_id);
  assign miss  = (state == S_SEARCH) && !rdv && !issue;
  assign full  = valid_entries == COUNT_W'(stt_pkg::TABLE_DEPTH);
  assign idx_in_range = stt_pkg::CMP_W'(req.entry_index) < stt_pkg::CMP_W'(valid_entries);

  // The read port follows the request index while idle and the scan pointer otherwise.
  assign ram_raddr = (state == S_IDLE) ? ADDR_W'(req.entry_index) : scan[ADDR_W-1:0];

  always_comb begin
    ram_we    = hit || (miss && !full);
    ram_waddr = hit ? rd_slot : valid_entries[ADDR_W-1:0];
    ram_wdata = ram_q;
    if (hit) begin
      ram_wdata.end_time    = op_tag;
      ram_wdata.frame_count = (ram_q.frame_count == '1) ? ram_q.frame_count
                                                        : ram_q.frame_count + 32'd1;
    end else begin
      ram_wdata.stream_id   = op_id;
      ram_wdata.frame_type  = op_type;
      ram_wdata.start_time  = op_tag;
      ram_wdata.end_time    = op_tag;
      ram_wdata.frame_count = 32'd1;
    end
  end

  stt_ram #(
    .DEPTH(stt_pkg::TABLE_DEPTH),
    .WIDTH($bits(stt_pkg::entry_t))
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid_entries <= '0;
      scan          <= '0;
      stopped       <= 1'b0;
      rdv           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // In S_EMIT the output register is reloaded below, so the flag is handled there.
      if (out_valid && rsp.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_id   <= req.stream_id;
            op_type <= req.frame_type;
            op_tag  <= req.time_tag;
            unique case (req.operation)
              stt_pkg::OP_RECORD: begin
                if (stopped) begin
                  res   <= stt_pkg::blank_result(stt_pkg::ST_FULL, '0, 8'(valid_entries));
                  state <= S_EMIT;
                end else begin
                  scan  <= '0;
                  rdv   <= 1'b0;
                  state <= S_SEARCH;
                end
              end
              stt_pkg::OP_READ: begin
                if (idx_in_range) begin
                  rd_slot <= ADDR_W'(req.entry_index);
                  state   <= S_READ;
                end else begin
                  res   <= stt_pkg::blank_result(stt_pkg::ST_EMPTY, req.entry_index,
                                                 8'(valid_entries));
                  state <= S_EMIT;
                end
              end
              stt_pkg::OP_CLEAR: begin
                valid_entries <= '0;
                stopped       <= 1'b0;
                res   <= stt_pkg::blank_result(stt_pkg::ST_CLEARED, '0, 8'd0);
                state <= S_EMIT;
              end
              default: begin
                res   <= stt_pkg::blank_result(stt_pkg::ST_EMPTY, '0, 8'(valid_entries));
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit) begin
            res   <= stt_pkg::entry_result((ram_q.frame_type == op_type) ? stt_pkg::ST_KNOWN
                                                                         : stt_pkg::ST_MISMATCH,
                                           7'(rd_slot), ram_wdata, 8'(valid_entries));
            state <= S_EMIT;
          end else if (miss) begin
            if (full) begin
              stopped <= 1'b1;
              res <= stt_pkg::blank_result(stt_pkg::ST_FULL, '0, 8'(valid_entries));
            end else begin
              valid_entries <= valid_entries + COUNT_W'(1);
              res <= stt_pkg::entry_result(stt_pkg::ST_NEW, 7'(valid_entries), ram_wdata,
                                           8'(valid_entries + COUNT_W'(1)));
            end
            state <= S_EMIT;
          end else begin
            // Entry data returns in the cycle after its address, so the compare trails the scan.
            rdv     <= issue;
            rd_slot <= scan[ADDR_W-1:0];
            if (issue) begin
              scan <= scan + COUNT_W'(1);
            end
          end
        end
        S_READ: begin
          res   <= stt_pkg::entry_result(stt_pkg::ST_READ_OK, 7'(rd_slot), ram_q,
                                         8'(valid_entries));
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_reg   <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready            = (state == S_IDLE);
  assign rsp.valid            = out_valid;
  assign rsp.status           = out_reg.status;
  assign rsp.slot             = out_reg.slot;
  assign rsp.entry_stream_id  = out_reg.entry_stream_id;
  assign rsp.entry_frame_type = out_reg.entry_frame_type;
  assign rsp.start_time       = out_reg.start_time;
  assign rsp.end_time         = out_reg.end_time;
  assign rsp.frame_count      = out_reg.frame_count;
  assign rsp.streams_seen     = out_reg.streams_seen;

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    valid_entries <= COUNT_W'(stt_pkg::TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_stop_only_full: assert property (@(posedge clk) disable iff (rst)
    stopped |-> full)
    else $error("stop flag set while table not full");

  a_write_in_search: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SEARCH) ##1 (state == S_EMIT))
    else $error("entry memory written outside a record update");

  a_compare_valid_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && rdv) |-> (COUNT_W'(rd_slot) < valid_entries))
    else $error("compare on an entry beyond the table fill");

endmodule

// File: rtl/stt_ram.sv
module stt_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 224
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/stream_statistics_table_tb.sv
module stream_statistics_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block has no name for the fourth operation code; it must answer as an empty read.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int TOTAL_ITEMS  = 1900;
  localparam int HOLD_AT_ITEM = 300;
  localparam int HOLD_CYCLES  = 1500;
  localparam int QUIET_FROM   = 900;
  localparam int QUIET_TO     = 1200;
  localparam int DRAIN_CYCLES = 150;
  localparam int POOL_MAX     = 140;

  typedef struct {
    logic [1:0]         operation;
    logic signed [31:0] stream_id;
    logic [31:0]        frame_type;
    logic [63:0]        time_tag;
    logic [6:0]         entry_index;
  } request_t;

  typedef struct {
    request_t         rq;
    bit               typed;
    stt_pkg::result_t want;
  } vector_t;

  logic clk;
  logic rst;

  stt_in_if  req_ch();
  stt_out_if rsp_ch();

  stream_statistics_table DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow of the stream table.
  logic signed [31:0] stream_ids  [stt_pkg::TABLE_DEPTH];
  logic [31:0]        first_types [stt_pkg::TABLE_DEPTH];
  logic [63:0]        first_tags  [stt_pkg::TABLE_DEPTH];
  logic [63:0]        last_tags   [stt_pkg::TABLE_DEPTH];
  logic [31:0]        frame_counts[stt_pkg::TABLE_DEPTH];
  int                 n_streams = 0;
  bit                 halted = 1'b0;

  stt_pkg::result_t pending_results[$];
  vector_t          directed_rows[$];
  int               n_sent = 0;
  int               error_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit quiet_stretch();
    return n_sent >= QUIET_FROM && n_sent < QUIET_TO;
  endfunction

  function automatic stt_pkg::result_t result_of(logic [2:0] status, logic [6:0] slot,
                                                 logic [31:0] id, logic [31:0] ftype,
                                                 logic [63:0] t_first, logic [63:0] t_last,
                                                 logic [31:0] count, logic [7:0] seen);
    stt_pkg::result_t r;
    r.status           = status;
    r.slot             = slot;
    r.entry_stream_id  = id;
    r.entry_frame_type = ftype;
    r.start_time       = t_first;
    r.end_time         = t_last;
    r.frame_count      = count;
    r.streams_seen     = seen;
    return r;
  endfunction

  function automatic stt_pkg::result_t entry_view(logic [2:0] status, int e);
    return result_of(status, e[6:0], stream_ids[e], first_types[e], first_tags[e],
                     last_tags[e], frame_counts[e], 8'd0);
  endfunction

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic stt_pkg::result_t table_response(request_t rq);
    stt_pkg::result_t r;
    int               hit;
    int               e;
    r   = '0;
    hit = -1;
    case (rq.operation)
      stt_pkg::OP_RECORD: begin
        if (halted) begin
          r.status = stt_pkg::ST_FULL;
        end else begin
          for (e = 0; e < n_streams; e++) begin
            if (hit < 0 && stream_ids[e] == rq.stream_id) hit = e;
          end
          if (hit >= 0) begin
            last_tags[hit] = rq.time_tag;
            if (frame_counts[hit] != '1) frame_counts[hit]++;
            r = entry_view((first_types[hit] == rq.frame_type) ? stt_pkg::ST_KNOWN
                                                               : stt_pkg::ST_MISMATCH, hit);
          end else if (n_streams >= stt_pkg::TABLE_DEPTH) begin
            halted   = 1'b1;
            r.status = stt_pkg::ST_FULL;
          end else begin
            stream_ids[n_streams]   = rq.stream_id;
            first_types[n_streams]  = rq.frame_type;
            first_tags[n_streams]   = rq.time_tag;
            last_tags[n_streams]    = rq.time_tag;
            frame_counts[n_streams] = 32'd1;
            r = entry_view(stt_pkg::ST_NEW, n_streams);
            n_streams++;
          end
        end
      end
      stt_pkg::OP_READ: begin
        if (rq.entry_index < n_streams) begin
          r = entry_view(stt_pkg::ST_READ_OK, rq.entry_index);
        end else begin
          r.status = stt_pkg::ST_EMPTY;
          r.slot   = rq.entry_index;
        end
      end
      stt_pkg::OP_CLEAR: begin
        n_streams = 0;
        halted    = 1'b0;
        r.status  = stt_pkg::ST_CLEARED;
      end
      default: begin
        r.status = stt_pkg::ST_EMPTY;
      end
    endcase
    r.streams_seen = n_streams[7:0];
    return r;
  endfunction

  function automatic request_t make_request(logic [1:0] op, logic [31:0] id,
                                            logic [31:0] ftype);
    request_t rq;
    rq.operation   = op;
    rq.stream_id   = id;
    rq.frame_type  = ftype;
    rq.time_tag    = {$urandom, $urandom};
    rq.entry_index = 7'($urandom_range(0, 127));
    return rq;
  endfunction

  task automatic add_vector(logic [1:0] op, logic [31:0] id, logic [31:0] ftype,
                            logic [63:0] tag, logic [6:0] idx, bit typed,
                            stt_pkg::result_t want);
    vector_t v;
    v.rq.operation   = op;
    v.rq.stream_id   = id;
    v.rq.frame_type  = ftype;
    v.rq.time_tag    = tag;
    v.rq.entry_index = idx;
    v.typed          = typed;
    v.want           = want;
    directed_rows.push_back(v);
  endtask

  // Offers one request, waits for its transfer, then records the expected response.
  task automatic send_request(request_t rq, bit typed, stt_pkg::result_t typed_want);
    stt_pkg::result_t want;
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= rq.operation;
    req_ch.stream_id   <= rq.stream_id;
    req_ch.frame_type  <= rq.frame_type;
    req_ch.time_tag    <= rq.time_tag;
    req_ch.entry_index <= rq.entry_index;
    do @(posedge clk); while (!req_ch.ready);
    want = table_response(rq);
    if (typed) want = typed_want;
    pending_results.push_back(want);
    n_sent++;
    if (!quiet_stretch()) begin
      while ($urandom_range(0, 99) < 28) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  initial begin
    vector_t            v;
    request_t           rq;
    logic signed [31:0] pool_ids  [POOL_MAX];
    logic [31:0]        pool_types[POOL_MAX];
    int                 pool_n;
    int                 len;
    int                 pick;
    int                 j;
    int                 top;
    bit                 fill;
    bit                 first_session;

    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= stt_pkg::OP_RECORD;
    req_ch.stream_id   <= '0;
    req_ch.frame_type  <= '0;
    req_ch.time_tag    <= '0;
    req_ch.entry_index <= '0;

    add_vector(stt_pkg::OP_READ, 0, 0, 0, 7'd0, 1'b1,
               result_of(stt_pkg::ST_EMPTY, 7'd0, 0, 0, 0, 0, 0, 8'd0));
    add_vector(stt_pkg::OP_READ, 0, 0, 0, 7'd127, 1'b1,
               result_of(stt_pkg::ST_EMPTY, 7'd127, 0, 0, 0, 0, 0, 8'd0));
    add_vector(OP_UNDEFINED, '1, '1, '1, 7'd127, 1'b1,
               result_of(stt_pkg::ST_EMPTY, 7'd0, 0, 0, 0, 0, 0, 8'd0));
    add_vector(stt_pkg::OP_RECORD, 32'h8000_0000, 0, 0, 7'd0, 1'b1,
               result_of(stt_pkg::ST_NEW, 7'd0, 32'h8000_0000, 0, 0, 0, 32'd1, 8'd1));
    add_vector(stt_pkg::OP_RECORD, 32'h7FFF_FFFF, '1, '1, 7'd127, 1'b1,
               result_of(stt_pkg::ST_NEW, 7'd1, 32'h7FFF_FFFF, '1, '1, '1, 32'd1, 8'd2));
    add_vector(stt_pkg::OP_RECORD, '1, 32'h5344_4946, 64'h0123_4567_89AB_CDEF, 7'd85,
               1'b0, '0);
    add_vector(stt_pkg::OP_RECORD, 32'h8000_0000, 0, 64'h8000_0000_0000_0000, 7'd0, 1'b1,
               result_of(stt_pkg::ST_KNOWN, 7'd0, 32'h8000_0000, 0, 0,
                         64'h8000_0000_0000_0000, 32'd2, 8'd3));
    // Same stream with a different frame type: still counted, flagged as a mismatch.
    add_vector(stt_pkg::OP_RECORD, 32'h7FFF_FFFF, 0, 64'd1, 7'd0, 1'b1,
               result_of(stt_pkg::ST_MISMATCH, 7'd1, 32'h7FFF_FFFF, '1, '1, 64'd1, 32'd2,
                         8'd3));
    add_vector(stt_pkg::OP_RECORD, 32'h7FFF_FFFF, '1, 64'd2, 7'd42, 1'b0, '0);
    add_vector(stt_pkg::OP_READ, 0, 0, 0, 7'd2, 1'b0, '0);
    add_vector(stt_pkg::OP_READ, '1, '1, '1, 7'd3, 1'b1,
               result_of(stt_pkg::ST_EMPTY, 7'd3, 0, 0, 0, 0, 0, 8'd3));
    add_vector(stt_pkg::OP_READ, 0, 0, 0, 7'd127, 1'b1,
               result_of(stt_pkg::ST_EMPTY, 7'd127, 0, 0, 0, 0, 0, 8'd3));
    add_vector(stt_pkg::OP_RECORD, 0, 32'd1, 64'd3, 7'd0, 1'b0, '0);
    add_vector(stt_pkg::OP_CLEAR, '1, '1, '1, 7'd127, 1'b1,
               result_of(stt_pkg::ST_CLEARED, 7'd0, 0, 0, 0, 0, 0, 8'd0));
    add_vector(stt_pkg::OP_READ, 0, 0, 0, 7'd0, 1'b1,
               result_of(stt_pkg::ST_EMPTY, 7'd0, 0, 0, 0, 0, 0, 8'd0));
    // After a clear the old entries are stale; a known id must come back as new.
    add_vector(stt_pkg::OP_RECORD, 0, 32'd2, 64'd4, 7'd0, 1'b1,
               result_of(stt_pkg::ST_NEW, 7'd0, 0, 32'd2, 64'd4, 64'd4, 32'd1, 8'd1));
    add_vector(stt_pkg::OP_RECORD, 32'h8000_0000, 32'h4641_5254, 64'd5, 7'd0, 1'b0, '0);
    add_vector(stt_pkg::OP_READ, 0, 0, 0, 7'd1, 1'b0, '0);
    add_vector(stt_pkg::OP_CLEAR, 0, 0, 0, 7'd0, 1'b1,
               result_of(stt_pkg::ST_CLEARED, 7'd0, 0, 0, 0, 0, 0, 8'd0));
    add_vector(stt_pkg::OP_CLEAR, 0, 0, 0, 7'd0, 1'b1,
               result_of(stt_pkg::ST_CLEARED, 7'd0, 0, 0, 0, 0, 0, 8'd0));
    add_vector(OP_UNDEFINED, 0, 0, 0, 7'd0, 1'b1,
               result_of(stt_pkg::ST_EMPTY, 7'd0, 0, 0, 0, 0, 0, 8'd0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      v = directed_rows[i];
      send_request(v.rq, v.typed, v.want);
    end

    // Sessions of frames over a pool of streams. Fill sessions draw a pool larger than the
    // table depth and record every pool stream in turn; the first session is a fill session.
    first_session = 1'b1;
    while (n_sent < TOTAL_ITEMS) begin
      fill          = first_session || ($urandom_range(0, 5) == 0);
      first_session = 1'b0;
      pool_n        = fill ? $urandom_range(stt_pkg::TABLE_DEPTH + 1, POOL_MAX)
                           : $urandom_range(1, 24);
      for (j = 0; j < pool_n; j++) begin
        pool_ids[j]   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) - 4 : $urandom;
        pool_types[j] = $urandom;
      end
      send_request(make_request(stt_pkg::OP_CLEAR, $urandom, $urandom), 1'b0, '0);
      len = fill ? pool_n + $urandom_range(5, 20) : $urandom_range(10, 60);
      for (j = 0; j < len; j++) begin
        pick = $urandom_range(0, 99);
        if (fill && j < pool_n) begin
          rq = make_request(stt_pkg::OP_RECORD, pool_ids[j], pool_types[j]);
        end else if (pick < 70) begin
          pick = $urandom_range(0, pool_n - 1);
          rq = make_request(stt_pkg::OP_RECORD, pool_ids[pick],
                            ($urandom_range(0, 9) == 0) ? $urandom : pool_types[pick]);
        end else if (pick < 78) begin
          rq = make_request(stt_pkg::OP_RECORD, $urandom, $urandom);
        end else if (pick < 92) begin
          rq  = make_request(stt_pkg::OP_READ, $urandom, $urandom);
          top = (n_streams + 2 > 127) ? 127 : n_streams + 2;
          if ($urandom_range(0, 1) == 0) rq.entry_index = 7'($urandom_range(0, top));
        end else if (pick < 96) begin
          rq = make_request(OP_UNDEFINED, $urandom, $urandom);
        end else begin
          rq = make_request(stt_pkg::OP_CLEAR, $urandom, $urandom);
        end
        send_request(rq, 1'b0, '0);
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("stream_statistics_table: match");
    end else begin
      $display("stream_statistics_table: mismatch");
    end
    $finish;
  end

  // Response side back-pressure, including one long hold-off that backs up the block.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && n_sent >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (quiet_stretch()) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 28);
      end
    end
  end

  initial begin
    stt_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("response transfer with no request outstanding: status 0x%0h",
                 rsp_ch.status);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", want.status, rsp_ch.status);
          compare_field("slot", want.slot, rsp_ch.slot);
          compare_field("entry_stream_id", want.entry_stream_id, rsp_ch.entry_stream_id);
          compare_field("entry_frame_type", want.entry_frame_type, rsp_ch.entry_frame_type);
          compare_field("start_time", want.start_time, rsp_ch.start_time);
          compare_field("end_time", want.end_time, rsp_ch.end_time);
          compare_field("frame_count", want.frame_count, rsp_ch.frame_count);
          compare_field("streams_seen", want.streams_seen, rsp_ch.streams_seen);
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("stream_statistics_table: mismatch");
    $finish;
  end

endmodule

// File: files.f
rtl/stt_pkg.sv
rtl/stt_ifs.sv
rtl/stt_ram.sv
rtl/stream_statistics_table.sv
tb/stream_statistics_table_tb.sv
